[hw/rtl/double_ended_queue_defines.svh]
// Assertion macros for the double-ended queue RTL, included by the top level.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define DEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`else

`define DEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/deq_pkg.sv]
// Types, codes and defaults shared by the double-ended queue modules.
`timescale 1ns / 1ps

package deq_pkg;

	// Default configuration
	localparam int DEPTH_DEF      = 16;
	localparam int WORD_WIDTH_DEF = 32;

	// Command codes
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
	localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;
	localparam logic [2:0] CMD_CLEAR      = 3'd6;

	// Status codes
	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	// Input item
	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] data_in;
	} deq_req_t;

	// Result item
	typedef struct packed {
		logic [31:0] data_out;
		logic [1:0]  status;
		logic        now_empty;
		logic [4:0]  entries;
	} deq_rsp_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       load;
		logic       exec;
		logic       wr_back;
		logic       wr_front;
		logic       rd_front;
		logic       rd_back;
		logic       pop_front;
		logic       pop_back;
		logic       clear;
		logic [1:0] status;
	} deq_op_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       full;
		logic       empty;
	} deq_stat_t;

endpackage

[hw/rtl/deq_ctrl.sv]
// Controller state machine of the double-ended queue.
`timescale 1ns / 1ps

module deq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  deq_pkg::deq_stat_t  stat,
	output logic                busy,
	output logic                done,
	output deq_pkg::deq_op_t    op
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EXEC  = 3'b010,
		ST_REPLY = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Advance through load, execute and reply
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_nxt = ST_EXEC;
			ST_EXEC:  state_nxt = ST_REPLY;
			ST_REPLY: state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Decode the held command against the full and empty flags
	always_comb begin
		op        = '0;
		op.status = deq_pkg::STS_DONE;
		op.load   = (state_q == ST_IDLE) && start;
		if (state_q == ST_EXEC) begin
			op.exec = 1'b1;
			unique case (stat.cmd)
				deq_pkg::CMD_PUSH_BACK, deq_pkg::CMD_PUSH_FRONT: begin
					if (stat.full) begin
						op.status = deq_pkg::STS_FULL;
					end else begin
						op.wr_back  = (stat.cmd == deq_pkg::CMD_PUSH_BACK);
						op.wr_front = (stat.cmd == deq_pkg::CMD_PUSH_FRONT);
					end
				end
				deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT: begin
					if (stat.empty) begin
						op.status = deq_pkg::STS_EMPTY;
					end else begin
						op.rd_front  = 1'b1;
						op.pop_front = (stat.cmd == deq_pkg::CMD_POP_FRONT);
					end
				end
				deq_pkg::CMD_POP_BACK, deq_pkg::CMD_PEEK_BACK: begin
					if (stat.empty) begin
						op.status = deq_pkg::STS_EMPTY;
					end else begin
						op.rd_back  = 1'b1;
						op.pop_back = (stat.cmd == deq_pkg::CMD_POP_BACK);
					end
				end
				deq_pkg::CMD_CLEAR: begin
					op.clear = 1'b1;
				end
				default: begin
					// Drop unused commands
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_REPLY);

endmodule

[hw/rtl/deq_dpath.sv]
// Datapath of the double-ended queue: ring store, front index and count.
`timescale 1ns / 1ps

module deq_dpath #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  deq_pkg::deq_req_t   req,
	input  deq_pkg::deq_op_t    op,
	output deq_pkg::deq_stat_t  stat,
	output deq_pkg::deq_rsp_t   rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_W   = (CW + 1)'(DEPTH);

	deq_pkg::deq_req_t   req_q;
	logic [WORD_WIDTH-1:0] mem [DEPTH];
	logic [WORD_WIDTH-1:0] rd_data_q;
	logic                  rd_valid_q;
	logic [1:0]            status_q;
	logic [AW-1:0]         front_q;
	logic [CW-1:0]         fill_q;

	logic [AW-1:0]         front_inc;
	logic [AW-1:0]         front_dec;
	logic [CW:0]           sum_w;
	logic [CW:0]           tail_w;
	logic [AW-1:0]         tail_slot;
	logic [AW-1:0]         last_slot;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [31:0]           fill_ext;

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (op.load) begin
			req_q <= req;
		end
	end

	// Slot arithmetic, modulo the depth
	always_comb begin
		front_inc = (front_q == LAST_SLOT) ? '0 : front_q + AW'(1);
		front_dec = (front_q == '0) ? LAST_SLOT : front_q - AW'(1);
		sum_w     = (CW + 1)'(front_q) + (CW + 1)'(fill_q);
		tail_w    = (sum_w >= DEPTH_W) ? sum_w - DEPTH_W : sum_w;
		tail_slot = tail_w[AW-1:0];
		last_slot = (tail_slot == '0) ? LAST_SLOT : tail_slot - AW'(1);
		wr_addr   = op.wr_front ? front_dec : tail_slot;
		rd_addr   = op.rd_front ? front_q : last_slot;
	end

	// Write and read the ring store
	always_ff @(posedge clk) begin
		if (op.wr_back || op.wr_front) begin
			mem[wr_addr] <= WORD_WIDTH'(req_q.data_in);
		end
		if (op.rd_front || op.rd_back) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Update front index, count and result status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			fill_q     <= '0;
			status_q   <= deq_pkg::STS_DONE;
			rd_valid_q <= 1'b0;
		end else begin
			if (op.exec) begin
				status_q   <= op.status;
				rd_valid_q <= op.rd_front || op.rd_back;
			end
			priority if (op.clear) begin
				front_q <= '0;
				fill_q  <= '0;
			end else if (op.wr_front) begin
				front_q <= front_dec;
				fill_q  <= fill_q + CW'(1);
			end else if (op.wr_back) begin
				fill_q <= fill_q + CW'(1);
			end else if (op.pop_front) begin
				front_q <= front_inc;
				fill_q  <= fill_q - CW'(1);
			end else if (op.pop_back) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	// Drive status and result
	always_comb begin
		fill_ext       = 32'(fill_q);
		stat.cmd       = req_q.cmd;
		stat.full      = (fill_q == FULL_CNT);
		stat.empty     = (fill_q == '0);
		rsp.data_out   = rd_valid_q ? 32'(rd_data_q) : 32'd0;
		rsp.status     = status_q;
		rsp.now_empty  = (fill_q == '0);
		rsp.entries    = fill_ext[4:0];
	end

endmodule

[hw/rtl/double_ended_queue.sv]
// Each command passes through load, execute against the ring store, and reply; a new command
// is accepted only while idle, once the reply of the last one has been given.
// The ring store has one port with a registered read, used at most once per command.
// Reset clears front index and count at once; the store itself is not cleared.
// The result strobe lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps

`include "double_ended_queue_defines.svh"

module double_ended_queue #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  deq_pkg::deq_req_t  req,
	output logic               done,
	output deq_pkg::deq_rsp_t  rsp
);

	deq_pkg::deq_op_t   op;
	deq_pkg::deq_stat_t stat;

	// Sequence each command
	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.op     (op)
	);

	// Hold the queue contents
	deq_dpath #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.op     (op),
		.stat   (stat),
		.rsp    (rsp)
	);

	// Checks
	`DEQ_ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, start && !busy, busy && !done)
	`DEQ_ASSERT_NEXT(a_single_strobe, clk, arst_n, done, !done && !busy)
	`DEQ_ASSERT_IMPL(a_empty_reply, clk, arst_n, done && (rsp.status == deq_pkg::STS_EMPTY), rsp.now_empty && (rsp.data_out == 32'd0))
	`DEQ_ASSERT_IMPL(a_full_reply, clk, arst_n, done && (rsp.status == deq_pkg::STS_FULL), !rsp.now_empty && (rsp.data_out == 32'd0))

endmodule

[tb/tb_double_ended_queue.sv]
// Self-checking testbench for the double-ended queue: directed table, then random command bursts.
`timescale 1ns / 1ps

module tb_double_ended_queue;
	import deq_pkg::*;

	localparam int         DEPTH       = DEPTH_DEF;
	localparam int         RANDOM_CMDS = 1100;
	localparam int         STALL_LIMIT = 2000;
	localparam int         DRAIN_TAIL  = 8;
	localparam logic [2:0] CMD_UNUSED  = 3'd7;

	// One row of the directed table; typed rows carry their own expected reply
	typedef struct {
		deq_req_t item;
		int       reps;
		bit       typed;
		deq_rsp_t want;
	} step_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	deq_req_t req;
	logic     done;
	deq_rsp_t rsp;

	// Shadow copy of the queue contents
	logic [31:0] shadow_words [DEPTH];
	int          shadow_front;
	int          shadow_count;

	deq_rsp_t awaited_rsp [$];
	step_t    plan [$];
	logic [2:0] push_codes [2];
	logic [2:0] take_codes [4];

	int  sent_cmds;
	int  directed_cmds;
	int  replies_seen;
	int  refused_pushes;
	int  empty_answers;
	int  peak_fill;
	int  mismatches;
	int  stall_cycles;
	bit  quiet;

	double_ended_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #2 clk = ~clk;

	// Apply one command to the shadow queue and return the reply it should give
	function automatic deq_rsp_t apply_command(deq_req_t r);
		deq_rsp_t o;
		int       slot;
		o = '0;
		case (r.cmd)
			CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
				if (shadow_count >= DEPTH) begin
					o.status = STS_FULL;
				end else begin
					if (r.cmd == CMD_PUSH_BACK) begin
						slot = (shadow_front + shadow_count) % DEPTH;
					end else begin
						slot = (shadow_front + DEPTH - 1) % DEPTH;
						shadow_front = slot;
					end
					shadow_words[slot] = r.data_in;
					shadow_count++;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
				if (shadow_count == 0) begin
					o.status = STS_EMPTY;
				end else begin
					if (r.cmd == CMD_POP_FRONT || r.cmd == CMD_PEEK_FRONT)
						slot = shadow_front;
					else
						slot = (shadow_front + shadow_count - 1) % DEPTH;
					o.data_out = shadow_words[slot];
					if (r.cmd == CMD_POP_FRONT) begin
						shadow_front = (shadow_front + 1) % DEPTH;
						shadow_count--;
					end else if (r.cmd == CMD_POP_BACK) begin
						shadow_count--;
					end
				end
			end
			CMD_CLEAR: begin
				shadow_front = 0;
				shadow_count = 0;
			end
			default: ;
		endcase
		o.now_empty = (shadow_count == 0);
		o.entries   = shadow_count[4:0];
		return o;
	endfunction

	function automatic step_t row(logic [2:0] c, logic [31:0] d, int n, bit t,
			logic [31:0] dout, logic [1:0] s, logic e, logic [4:0] ent);
		step_t x;
		x.item.cmd       = c;
		x.item.data_in   = d;
		x.reps           = n;
		x.typed          = t;
		x.want.data_out  = dout;
		x.want.status    = s;
		x.want.now_empty = e;
		x.want.entries   = ent;
		return x;
	endfunction

	// Offer one item, with a random hold-off outside the quiet stretch, and queue its expected reply
	task automatic send(input deq_req_t item, input bit typed, input deq_rsp_t want);
		deq_rsp_t predicted;
		while (!quiet && $urandom_range(99) < 10) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = apply_command(item);
		awaited_rsp.push_back(typed ? want : predicted);
		sent_cmds++;
		if (shadow_count > peak_fill)
			peak_fill = shadow_count;
	endtask

	// Check each reply against the oldest expectation
	always @(posedge clk) begin
		deq_rsp_t exp_rsp;
		if (arst_n && done) begin
			replies_seen++;
			if (rsp.status == STS_FULL)
				refused_pushes++;
			if (rsp.status == STS_EMPTY)
				empty_answers++;
			if (awaited_rsp.size() == 0) begin
				$error("reply with no command outstanding: %p", rsp);
				mismatches++;
			end else begin
				exp_rsp = awaited_rsp.pop_front();
				if (rsp.data_out !== exp_rsp.data_out) begin
					$error("data_out: expected %h, got %h", exp_rsp.data_out, rsp.data_out);
					mismatches++;
				end
				if (rsp.status !== exp_rsp.status) begin
					$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
					mismatches++;
				end
				if (rsp.now_empty !== exp_rsp.now_empty) begin
					$error("now_empty: expected %b, got %b", exp_rsp.now_empty, rsp.now_empty);
					mismatches++;
				end
				if (rsp.entries !== exp_rsp.entries) begin
					$error("entries: expected %0d, got %0d", exp_rsp.entries, rsp.entries);
					mismatches++;
				end
			end
		end
	end

	// Count cycles in which nothing moves in either direction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Timeout: no traffic for %0d cycles, %0d replies outstanding",
			STALL_LIMIT, awaited_rsp.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [2:0]  cmd;
		logic [31:0] data;
		deq_req_t    item;
		int          mode;
		int          burst;
		int          pick;
		int          random_sent;

		arst_n         = 1'b0;
		start          = 1'b0;
		req            = '0;
		shadow_front   = 0;
		shadow_count   = 0;
		sent_cmds      = 0;
		replies_seen   = 0;
		refused_pushes = 0;
		empty_answers  = 0;
		peak_fill      = 0;
		mismatches     = 0;
		stall_cycles   = 0;
		quiet          = 1'b0;
		push_codes     = '{CMD_PUSH_BACK, CMD_PUSH_FRONT};
		take_codes     = '{CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK};

		// Empty answers, extreme words, the unused code, wrap below slot zero, full refusal, clear
		plan.push_back(row(CMD_PEEK_FRONT, 32'h0000_0000, 1, 1, 32'h0, STS_EMPTY, 1'b1, 5'd0));
		plan.push_back(row(CMD_POP_BACK, 32'hFFFF_FFFF, 1, 1, 32'h0, STS_EMPTY, 1'b1, 5'd0));
		plan.push_back(row(CMD_PUSH_BACK, 32'hFFFF_FFFF, 1, 1, 32'h0, STS_DONE, 1'b0, 5'd1));
		plan.push_back(row(CMD_PUSH_FRONT, 32'h0000_0000, 1, 1, 32'h0, STS_DONE, 1'b0, 5'd2));
		plan.push_back(row(CMD_PEEK_BACK, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, STS_DONE,
			1'b0, 5'd2));
		plan.push_back(row(CMD_UNUSED, 32'hFFFF_FFFF, 1, 1, 32'h0, STS_DONE, 1'b0, 5'd2));
		plan.push_back(row(CMD_PUSH_FRONT, 32'hA5A5_0000, 14, 0, '0, '0, 1'b0, '0));
		plan.push_back(row(CMD_PUSH_BACK, 32'h1234_5678, 1, 1, 32'h0, STS_FULL, 1'b0, 5'd16));
		plan.push_back(row(CMD_PUSH_FRONT, 32'h8765_4321, 1, 1, 32'h0, STS_FULL, 1'b0, 5'd16));
		plan.push_back(row(CMD_POP_BACK, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, STS_DONE,
			1'b0, 5'd15));
		plan.push_back(row(CMD_POP_FRONT, 32'h0000_0000, 1, 0, '0, '0, 1'b0, '0));
		plan.push_back(row(CMD_PEEK_FRONT, 32'h0000_0000, 1, 0, '0, '0, 1'b0, '0));
		plan.push_back(row(CMD_CLEAR, 32'h5A5A_5A5A, 1, 1, 32'h0, STS_DONE, 1'b1, 5'd0));
		plan.push_back(row(CMD_POP_FRONT, 32'h0000_0000, 1, 1, 32'h0, STS_EMPTY, 1'b1, 5'd0));
		plan.push_back(row(CMD_PEEK_BACK, 32'h0000_0000, 1, 1, 32'h0, STS_EMPTY, 1'b1, 5'd0));
		plan.push_back(row(CMD_UNUSED, 32'h0000_0000, 1, 1, 32'h0, STS_DONE, 1'b1, 5'd0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (plan[i]) begin
			for (int k = 0; k < plan[i].reps; k++) begin
				item = plan[i].item;
				item.data_in = item.data_in + k;
				send(item, plan[i].typed, plan[i].want);
			end
		end
		directed_cmds = sent_cmds;

		// Random bursts: fill-heavy, drain-heavy or mixed, so the queue swings full and empty
		random_sent = 0;
		while (random_sent < RANDOM_CMDS) begin
			mode  = $urandom_range(2);
			burst = $urandom_range(60, 10);
			for (int k = 0; k < burst; k++) begin
				pick = $urandom_range(99);
				case (mode)
					0:       cmd = (pick < 75) ? push_codes[$urandom_range(1)]
					                           : take_codes[$urandom_range(3)];
					1:       cmd = (pick < 75) ? take_codes[$urandom_range(3)]
					                           : push_codes[$urandom_range(1)];
					default: begin
						if (pick < 45)
							cmd = push_codes[$urandom_range(1)];
						else if (pick < 90)
							cmd = take_codes[$urandom_range(3)];
						else if (pick < 95)
							cmd = CMD_CLEAR;
						else
							cmd = CMD_UNUSED;
					end
				endcase
				case ($urandom_range(7))
					0:       data = 32'h0000_0000;
					1:       data = 32'hFFFF_FFFF;
					default: data = $urandom;
				endcase
				item.cmd     = cmd;
				item.data_in = data;
				// Hold back-to-back offers through one long stretch
				quiet = (random_sent >= 400 && random_sent < 650);
				send(item, 1'b0, '0);
				random_sent++;
			end
		end
		quiet = 1'b0;
		start <= 1'b0;

		// Drain outstanding replies, then watch for strays
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("Sent %0d commands (%0d directed), checked %0d replies", sent_cmds,
			directed_cmds, replies_seen);
		$display("Refused pushes %0d, empty answers %0d, peak fill %0d of %0d",
			refused_pushes, empty_answers, peak_fill, DEPTH);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
